// ----- rtl/pwpt_pkg.sv -----
// Shared widths, codes and stage types of the winding-number point test.
`default_nettype none
package pwpt_pkg;

	localparam int COORD_BITS   = 32;
	localparam int WINDING_BITS = 16;

	localparam int VTX_W   = 32;
	localparam int TOTAL_W = 16;
	localparam int EXT_W   = 32;
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;

	localparam logic signed [WINDING_BITS-1:0] CNT_MAX = {1'b0, {(WINDING_BITS-1){1'b1}}};
	localparam logic signed [WINDING_BITS-1:0] CNT_MIN = {1'b1, {(WINDING_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		CONT_OUTSIDE = 2'd0,
		CONT_INSIDE  = 2'd1,
		CONT_ON_EDGE = 2'd2
	} containment_t;

	// Per-edge tests and cross product operands.
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic              degen;
		logic              y_out;
		logic              upward;
		logic              downward;
		logic              on_span;
		logic [DIFF_W-1:0] dx1;
		logic [DIFF_W-1:0] dy21;
		logic [DIFF_W-1:0] dx21;
		logic [DIFF_W-1:0] dyq;
	} edge_t;

	// Per-edge tests and the two cross product terms.
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic              degen;
		logic              y_out;
		logic              upward;
		logic              downward;
		logic              on_span;
		logic [PROD_W-1:0] p1;
		logic [PROD_W-1:0] p2;
	} cross_t;

endpackage
`default_nettype wire

// ----- rtl/pwpt_edge_front.sv -----
// Input register, held vertex and query point, and per-edge differences and range tests.
`default_nettype none
module pwpt_edge_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [pwpt_pkg::VTX_W-1:0]   vertex_x,
	input  logic signed [pwpt_pkg::VTX_W-1:0]   vertex_y,
	input  logic signed [pwpt_pkg::VTX_W-1:0]   query_x,
	input  logic signed [pwpt_pkg::VTX_W-1:0]   query_y,
	input  logic                                first_vertex,
	input  logic                                last_vertex,
	input  logic                                s2_ready,
	output pwpt_pkg::edge_t                     edge_s2
);

	typedef struct packed {
		logic                                valid;
		logic                                first;
		logic                                last;
		logic [pwpt_pkg::COORD_BITS-1:0]     x1;
		logic [pwpt_pkg::COORD_BITS-1:0]     y1;
		logic [pwpt_pkg::COORD_BITS-1:0]     x2;
		logic [pwpt_pkg::COORD_BITS-1:0]     y2;
		logic [pwpt_pkg::COORD_BITS-1:0]     px;
		logic [pwpt_pkg::COORD_BITS-1:0]     py;
	} front_t;

	front_t                            vtx_s1;
	logic [pwpt_pkg::COORD_BITS-1:0]   prev_x_q, prev_y_q, point_x_q, point_y_q;
	logic                              s2_load, s1_ready, accept;
	logic signed [pwpt_pkg::COORD_BITS-1:0] x1, y1, x2, y2, px, py;
	pwpt_pkg::edge_t                   edge_nxt;

	assign s2_load  = !edge_s2.valid || s2_ready;
	assign s1_ready = !vtx_s1.valid || s2_load;
	assign in_stall = !s1_ready;
	assign accept   = in_valid && s1_ready;

	// Hold the last vertex and the query point; both follow the accepted beats only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			point_x_q <= '0;
			point_y_q <= '0;
		end else if (accept) begin
			prev_x_q <= vertex_x[pwpt_pkg::COORD_BITS-1:0];
			prev_y_q <= vertex_y[pwpt_pkg::COORD_BITS-1:0];
			if (first_vertex) begin
				point_x_q <= query_x[pwpt_pkg::COORD_BITS-1:0];
				point_y_q <= query_y[pwpt_pkg::COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_s1 <= '0;
		end else if (s1_ready) begin
			vtx_s1.valid <= in_valid;
			vtx_s1.first <= first_vertex;
			vtx_s1.last  <= last_vertex;
			vtx_s1.x1    <= prev_x_q;
			vtx_s1.y1    <= prev_y_q;
			vtx_s1.x2    <= vertex_x[pwpt_pkg::COORD_BITS-1:0];
			vtx_s1.y2    <= vertex_y[pwpt_pkg::COORD_BITS-1:0];
			vtx_s1.px    <= first_vertex ? query_x[pwpt_pkg::COORD_BITS-1:0] : point_x_q;
			vtx_s1.py    <= first_vertex ? query_y[pwpt_pkg::COORD_BITS-1:0] : point_y_q;
		end
	end

	assign x1 = $signed(vtx_s1.x1);
	assign y1 = $signed(vtx_s1.y1);
	assign x2 = $signed(vtx_s1.x2);
	assign y2 = $signed(vtx_s1.y2);
	assign px = $signed(vtx_s1.px);
	assign py = $signed(vtx_s1.py);

	always_comb begin
		edge_nxt          = '0;
		edge_nxt.valid    = vtx_s1.valid;
		edge_nxt.first    = vtx_s1.first;
		edge_nxt.last     = vtx_s1.last;
		edge_nxt.degen    = (x1 == x2) && (y1 == y2);
		edge_nxt.y_out    = !(((y1 <= py) && (py <= y2)) || ((y2 <= py) && (py <= y1)));
		edge_nxt.upward   = (y1 < py) && (py <= y2);
		edge_nxt.downward = (y2 <= py) && (py < y1);
		edge_nxt.on_span  = ((x1 <= px) && (px < x2)) || ((x1 >= px) && (px > x2)) ||
		                    ((y1 <= py) && (py < y2)) || ((y1 >= py) && (py > y2));
		edge_nxt.dx1      = pwpt_pkg::DIFF_W'(px) - pwpt_pkg::DIFF_W'(x1);
		edge_nxt.dy21     = pwpt_pkg::DIFF_W'(y2) - pwpt_pkg::DIFF_W'(y1);
		edge_nxt.dx21     = pwpt_pkg::DIFF_W'(x2) - pwpt_pkg::DIFF_W'(x1);
		edge_nxt.dyq      = pwpt_pkg::DIFF_W'(py) - pwpt_pkg::DIFF_W'(y1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_s2 <= '0;
		end else if (s2_load) begin
			edge_s2 <= edge_nxt;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pwpt_cross_mul.sv -----
// Cross product stage: the two signed products of the edge test, registered.
`default_nettype none
module pwpt_cross_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  pwpt_pkg::edge_t  edge_s2,
	output logic             s2_ready,
	output pwpt_pkg::cross_t cross_s3,
	input  logic             s3_ready
);

	logic                                  s3_load;
	logic signed [pwpt_pkg::PROD_W-1:0]    prod1, prod2;

	assign s3_load  = !cross_s3.valid || s3_ready;
	assign s2_ready = s3_load;

	assign prod1 = $signed(edge_s2.dx1) * $signed(edge_s2.dy21);
	assign prod2 = $signed(edge_s2.dx21) * $signed(edge_s2.dyq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_s3 <= '0;
		end else if (s3_load) begin
			cross_s3.valid    <= edge_s2.valid;
			cross_s3.first    <= edge_s2.first;
			cross_s3.last     <= edge_s2.last;
			cross_s3.degen    <= edge_s2.degen;
			cross_s3.y_out    <= edge_s2.y_out;
			cross_s3.upward   <= edge_s2.upward;
			cross_s3.downward <= edge_s2.downward;
			cross_s3.on_span  <= edge_s2.on_span;
			cross_s3.p1       <= prod1;
			cross_s3.p2       <= prod2;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pwpt_tally.sv -----
// Winding count and on-edge flag update, and the result register.
`default_nettype none
module pwpt_tally (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pwpt_pkg::cross_t                       cross_s3,
	output logic                                   s3_ready,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [1:0]                             containment,
	output logic signed [pwpt_pkg::TOTAL_W-1:0]    winding_total
);

	logic signed [pwpt_pkg::WINDING_BITS-1:0] count_q, count_nxt;
	logic                                     on_edge_q, on_edge_nxt;
	logic                                     out_free, retire, lt, eq;
	logic signed [pwpt_pkg::EXT_W-1:0]        count_ext;
	pwpt_pkg::containment_t                   cont_nxt;
	logic                                     ov_q;
	logic [1:0]                               cont_q;
	logic signed [pwpt_pkg::TOTAL_W-1:0]      total_q;

	assign out_free = !ov_q || !out_stall;
	// Retire an item freely unless it carries a result and the result register is full and stalled.
	assign retire   = cross_s3.valid && (!cross_s3.last || out_free);
	assign s3_ready = retire;

	assign lt = $signed(cross_s3.p1) < $signed(cross_s3.p2);
	assign eq = cross_s3.p1 == cross_s3.p2;

	always_comb begin
		count_nxt   = count_q;
		on_edge_nxt = on_edge_q;
		if (cross_s3.first) begin
			count_nxt   = '0;
			on_edge_nxt = 1'b0;
		end else if (!on_edge_q && !cross_s3.degen && !cross_s3.y_out) begin
			if (eq) begin
				if (cross_s3.on_span) begin
					on_edge_nxt = 1'b1;
				end
			end else if (lt) begin
				if (cross_s3.upward && (count_q < pwpt_pkg::CNT_MAX)) begin
					count_nxt = count_q + pwpt_pkg::WINDING_BITS'(1);
				end
			end else begin
				if (cross_s3.downward && (count_q > pwpt_pkg::CNT_MIN)) begin
					count_nxt = count_q - pwpt_pkg::WINDING_BITS'(1);
				end
			end
		end
	end

	always_comb begin
		if (on_edge_nxt) begin
			cont_nxt = pwpt_pkg::CONT_ON_EDGE;
		end else if (count_nxt != '0) begin
			cont_nxt = pwpt_pkg::CONT_INSIDE;
		end else begin
			cont_nxt = pwpt_pkg::CONT_OUTSIDE;
		end
	end

	assign count_ext = pwpt_pkg::EXT_W'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			on_edge_q <= 1'b0;
		end else if (retire) begin
			count_q   <= count_nxt;
			on_edge_q <= on_edge_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (retire && cross_s3.last) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && cross_s3.last) begin
			cont_q  <= cont_nxt;
			total_q <= count_ext[pwpt_pkg::TOTAL_W-1:0];
		end
	end

	assign out_valid     = ov_q;
	assign containment   = cont_q;
	assign winding_total = total_q;

`ifndef SYNTHESIS
	a_frozen_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		on_edge_q && !(retire && cross_s3.first) |=> $stable(count_q))
		else $error("winding count moved after on-edge was seen");

	a_no_wrap_up: assert property (@(posedge clk) disable iff (!arst_n)
		retire && !cross_s3.first && count_q == pwpt_pkg::CNT_MAX |=> count_q != pwpt_pkg::CNT_MIN)
		else $error("winding count wrapped past its maximum");

	a_no_wrap_down: assert property (@(posedge clk) disable iff (!arst_n)
		retire && !cross_s3.first && count_q == pwpt_pkg::CNT_MIN |=> count_q != pwpt_pkg::CNT_MAX)
		else $error("winding count wrapped past its minimum");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && out_stall |-> !(retire && cross_s3.last))
		else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire

// ----- rtl/polygon_winding_point_test_unit.sv -----
// Top level of the streaming winding-number point-in-polygon test.
`default_nettype none
// Feed one polygon vertex per input beat. The beat flagged first_vertex clears the
// winding count and on-edge flag and latches query_x/query_y; every later beat closes
// the edge from the previous vertex to its own. A beat flagged last_vertex yields one
// result beat: containment (0 outside, 1 inside, 2 on edge) and the saturated winding
// count in its low 16 bits. Close the polygon by repeating the first vertex at the end.
// Throughput is one vertex per clock while the pipe is not backed up; a result passes
// the input register, the difference stage and the multiplier stage into the result
// register. The multiplier stage, two 33x33 signed products, sets the clock.
// Beats that carry no result retire even while the output is stalled, so the pipe
// only backs up when a result beat meets a full result register that is stalled.
module polygon_winding_point_test_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    vertex_x,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    vertex_y,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    query_x,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    query_y,
	input  logic                                 first_vertex,
	input  logic                                 last_vertex,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           containment,
	output logic signed [pwpt_pkg::TOTAL_W-1:0]  winding_total
);

	pwpt_pkg::edge_t  edge_s2;
	pwpt_pkg::cross_t cross_s3;
	logic             s2_ready, s3_ready;

	// Latch the vertex, form edge differences and range tests.
	pwpt_edge_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.query_x      (query_x),
		.query_y      (query_y),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.s2_ready     (s2_ready),
		.edge_s2      (edge_s2)
	);

	// Form both cross product terms.
	pwpt_cross_mul u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.edge_s2  (edge_s2),
		.s2_ready (s2_ready),
		.cross_s3 (cross_s3),
		.s3_ready (s3_ready)
	);

	// Compare the terms, advance the count and flag, and drive the result beat.
	pwpt_tally u_tally (
		.clk           (clk),
		.arst_n        (arst_n),
		.cross_s3      (cross_s3),
		.s3_ready      (s3_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.containment   (containment),
		.winding_total (winding_total)
	);

endmodule
`default_nettype wire

// ----- tb/pwpt_containment_checker.sv -----
// Checker for the winding-number point test: predicts each verdict and compares results.
`timescale 1ns / 100ps
module pwpt_containment_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    vertex_x,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    vertex_y,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    query_x,
	input  logic signed [pwpt_pkg::VTX_W-1:0]    query_y,
	input  logic                                 first_vertex,
	input  logic                                 last_vertex,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [1:0]                           containment,
	input  logic signed [pwpt_pkg::TOTAL_W-1:0]  winding_total,
	output int                                   mismatches,
	output int                                   verdicts_pending
);

	typedef logic signed [pwpt_pkg::VTX_W-1:0] coord_t;
	typedef logic signed [pwpt_pkg::PROD_W-1:0] wide_t;

	typedef struct packed {
		pwpt_pkg::containment_t                place;
		logic signed [pwpt_pkg::TOTAL_W-1:0]   total;
	} verdict_t;

	verdict_t expected_verdicts[$];

	coord_t held_x, held_y, probe_x, probe_y;
	logic signed [pwpt_pkg::WINDING_BITS-1:0] winding;
	logic edge_hit;
	int fail_tally;

	// Close the edge from the held vertex to (nx, ny) and update the count or the flag.
	task automatic close_edge(input coord_t nx, input coord_t ny);
		wide_t ax, ay, bx, by, px, py, ymin, ymax, lhs, rhs;
		ax = held_x;
		ay = held_y;
		bx = nx;
		by = ny;
		px = probe_x;
		py = probe_y;
		ymin = (ay < by) ? ay : by;
		ymax = (ay < by) ? by : ay;
		if (!edge_hit && !(ax == bx && ay == by) && py <= ymax && py >= ymin) begin
			lhs = (px - ax) * (by - ay);
			rhs = (bx - ax) * (py - ay);
			if (lhs == rhs) begin
				if ((ax <= px && px < bx) || (ax >= px && px > bx) ||
				    (ay <= py && py < by) || (ay >= py && py > by))
					edge_hit = 1'b1;
			end else if (lhs < rhs) begin
				if (ay < py && py <= by && winding != pwpt_pkg::CNT_MAX)
					winding = winding + 1'b1;
			end else begin
				if (by <= py && py < ay && winding != pwpt_pkg::CNT_MIN)
					winding = winding - 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			held_x = '0;
			held_y = '0;
			probe_x = '0;
			probe_y = '0;
			winding = '0;
			edge_hit = 1'b0;
			fail_tally = 0;
			expected_verdicts.delete();
			mismatches <= 0;
			verdicts_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: result beat with none expected: containment %0d, total %0d",
						$time, containment, winding_total);
					fail_tally++;
				end else begin
					want = expected_verdicts.pop_front();
					if (containment !== want.place) begin
						$display("%0t: containment mismatch, expected %0d, got %0d",
							$time, want.place, containment);
						fail_tally++;
					end
					if (winding_total !== want.total) begin
						$display("%0t: winding_total mismatch, expected %0d, got %0d",
							$time, want.total, winding_total);
						fail_tally++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (first_vertex) begin
					probe_x = query_x;
					probe_y = query_y;
					winding = '0;
					edge_hit = 1'b0;
				end else begin
					close_edge(vertex_x, vertex_y);
				end
				held_x = vertex_x;
				held_y = vertex_y;
				if (last_vertex) begin
					want.place = edge_hit ? pwpt_pkg::CONT_ON_EDGE :
						(winding != 0 ? pwpt_pkg::CONT_INSIDE : pwpt_pkg::CONT_OUTSIDE);
					want.total = winding[pwpt_pkg::TOTAL_W-1:0];
					expected_verdicts.push_back(want);
				end
			end
			mismatches <= fail_tally;
			verdicts_pending <= expected_verdicts.size();
		end
	end

endmodule

// ----- tb/polygon_winding_point_test_unit_tb.sv -----
// Testbench top: drives vertex beats and result stalls into the point test and gives the verdict.
`timescale 1ns / 100ps
module polygon_winding_point_test_unit_tb;

	typedef logic signed [pwpt_pkg::VTX_W-1:0] coord_t;

	localparam int HALF_PERIOD  = 10;
	localparam int LATENCY      = 4;
	localparam int IDLE_LIMIT   = 4000;   // cycles with no beat on either side
	localparam int HOLD_CYCLES  = 400;    // long result hold-off under pressure
	localparam int WIND_LAPS    = 40;     // laps around the origin in one direction
	localparam int RANDOM_ITEMS = 1465;

	localparam coord_t C_MIN = {1'b1, {(pwpt_pkg::VTX_W-1){1'b0}}};
	localparam coord_t C_MAX = {1'b0, {(pwpt_pkg::VTX_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [pwpt_pkg::VTX_W-1:0] vertex_x, vertex_y, query_x, query_y;
	logic first_vertex, last_vertex;
	logic out_valid;
	logic out_stall;
	logic [1:0] containment;
	logic signed [pwpt_pkg::TOTAL_W-1:0] winding_total;
	int mismatches;
	int verdicts_pending;

	// hold_req is shared between the sender and the receiver; the rest serves the sender and the watchdog.
	bit hold_req = 1'b0;
	bit steady = 1'b0;
	int idle_cycles = 0;
	int random_items = 0;
	coord_t ring_x[$], ring_y[$];

	always #(HALF_PERIOD) clk = ~clk;

	polygon_winding_point_test_unit dut (.*);

	pwpt_containment_checker checker_i (.*);

	// Mostly short pauses, now and then a long one.
	function automatic int random_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic int next_gap();
		return steady ? 0 : random_pause();
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return '0;
			3: return '1;
			default: return coord_t'(1);
		endcase
	endfunction

	function automatic coord_t pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return coord_t'($urandom);
		else if (r < 85)
			return pick_extreme();
		else
			return coord_t'(int'($urandom_range(0, 16)) - 8);
	endfunction

	// Offer one vertex beat after `gap` idle cycles and hold it until it is taken.
	task automatic send_vertex(input coord_t vx, input coord_t vy, input coord_t qx,
		input coord_t qy, input logic first, input logic last, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vertex_x <= vx;
		vertex_y <= vy;
		query_x <= qx;
		query_y <= qy;
		first_vertex <= first;
		last_vertex <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Stream the vertices held in ring_x/ring_y as one polygon around (qx, qy).
	task automatic send_ring(input coord_t qx, input coord_t qy, input bit mark_first,
		input bit mark_last);
		int n;
		n = ring_x.size();
		for (int i = 0; i < n; i++)
			send_vertex(ring_x[i], ring_y[i], (i == 0) ? qx : coord_t'($urandom),
				(i == 0) ? qy : coord_t'($urandom),
				mark_first && i == 0, mark_last && i == n - 1, next_gap());
	endtask

	// Drop valid and hold off until every verdict has come back and the pipe is empty.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdicts_pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Wind around the origin many times, in one direction.
	task automatic wind_laps(input bit ccw);
		coord_t lx[3], ly[3];
		if (ccw) begin
			lx = '{0, -2, 2};
			ly = '{2, -1, -1};
		end else begin
			lx = '{-2, 0, 2};
			ly = '{-1, 2, -1};
		end
		send_vertex(2, -1, 0, 0, 1'b1, 1'b0, 0);
		for (int i = 0; i < WIND_LAPS; i++)
			for (int k = 0; k < 3; k++)
				send_vertex(lx[k], ly[k], coord_t'($urandom), coord_t'($urandom), 1'b0,
					i == WIND_LAPS - 1 && k == 2, 0);
	endtask

	// Build one polygon: mostly a small grid around the query point, scaled at times,
	// sometimes fully random or pinned to extremes, with repeats, open ends and
	// missing first or last marks mixed in.
	task automatic send_random_polygon();
		coord_t qx, qy;
		int n, shift, mode, ox, oy;
		qx = pick_coord();
		qy = pick_coord();
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
		shift = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
		mode = $urandom_range(0, 9);
		ring_x.delete();
		ring_y.delete();
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 9) == 0) begin
				ring_x.push_back(ring_x[i-1]);
				ring_y.push_back(ring_y[i-1]);
			end else if (mode == 0) begin
				ring_x.push_back(coord_t'($urandom));
				ring_y.push_back(coord_t'($urandom));
			end else if (mode == 1) begin
				ring_x.push_back(pick_extreme());
				ring_y.push_back(pick_extreme());
			end else begin
				ox = int'($urandom_range(0, 8)) - 4;
				oy = int'($urandom_range(0, 8)) - 4;
				ring_x.push_back(qx + (coord_t'(ox) <<< shift));
				ring_y.push_back(qy + (coord_t'(oy) <<< shift));
			end
		end
		if (n > 1 && $urandom_range(0, 99) < 85) begin
			ring_x.push_back(ring_x[0]);
			ring_y.push_back(ring_y[0]);
		end
		steady = ($urandom_range(0, 4) == 0);
		send_ring(qx, qy, $urandom_range(0, 11) != 0, $urandom_range(0, 11) != 0);
		random_items += ring_x.size();
	endtask

	// Receiver: random stalls of mixed length, free-running stretches, and one long
	// hold-off on request so that result beats back up into the input.
	initial begin
		int stall_left, free_left;
		stall_left = 0;
		free_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (free_left > 0) begin
				out_stall <= 1'b0;
				free_left--;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 1) == 1)
					stall_left = random_pause();
				else
					free_left = $urandom_range(1, 40);
			end
		end
	end

	// Watchdog: end the run if neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		query_x = '0;
		query_y = '0;
		first_vertex = 1'b0;
		last_vertex = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// No first vertex yet: edges start at the reset vertex, probed at the origin,
		// and the very first edge grazes the origin. Then keep accumulating past a last.
		send_vertex(3, 4, C_MAX, C_MIN, 1'b0, 1'b0, 0);
		send_vertex(-2, 7, 5, 5, 1'b0, 1'b1, 0);
		send_vertex(9, 9, -5, 5, 1'b0, 1'b1, 1);

		// First and last on one beat: outside, count zero.
		send_vertex(C_MIN, C_MAX, C_MAX, C_MIN, 1'b1, 1'b1, 0);

		// Counter-clockwise triangle around the origin, then clockwise with a repeat.
		ring_x = {2, 0, -2, 2};
		ring_y = {-1, 2, -1, -1};
		send_ring(0, 0, 1'b1, 1'b1);
		ring_x = {2, -2, -2, 0, 2};
		ring_y = {-1, -1, -1, 2, -1};
		send_ring(0, 0, 1'b1, 1'b1);

		// Cross once, land on an edge, then cross again: the count must stay frozen.
		ring_x = {2, 0, 0, 5, 5};
		ring_y = {-1, 2, -3, -3, 3};
		send_ring(0, 0, 1'b1, 1'b1);

		// Full-range square: largest products on both sides of the compare.
		ring_x = {C_MIN, C_MAX, C_MAX, C_MIN, C_MIN};
		ring_y = {C_MIN, C_MIN, C_MAX, C_MAX, C_MIN};
		send_ring(0, 0, 1'b1, 1'b1);

		// Pause until every verdict so far has come back.
		drain();

		// Wind around the origin many times upward, then downward.
		steady = 1'b1;
		wind_laps(1'b1);
		wind_laps(1'b0);
		drain();

		// Hold the receiver off while polygons keep streaming back to back.
		hold_req = 1'b1;
		steady = 1'b1;
		for (int i = 0; i < 30; i++) begin
			ring_x = {2, 0, -2, 2};
			ring_y = {-1, 2, -1, -1};
			if (i % 2 == 1)
				ring_x.reverse();
			send_ring(coord_t'($urandom_range(0, 2)) - 1, coord_t'($urandom_range(0, 2)) - 1,
				1'b1, 1'b1);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (hold_req) @(posedge clk);

		// Random polygons.
		while (random_items < RANDOM_ITEMS)
			send_random_polygon();

		drain();
		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
